FILE: hw/rtl/pll_ssc_coefficient_calc_top_assert.svh
`ifndef PLL_SSC_COEFFICIENT_CALC_TOP_ASSERT_SVH
`define PLL_SSC_COEFFICIENT_CALC_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PSCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pscc assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PSCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pscc assertion failed");

`endif

FILE: hw/rtl/pscc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pscc_pkg;

	// input limits and scaling
	localparam logic [11:0] FREQ_MIN  = 12'd64;
	localparam logic [7:0]  SCALE_DEN = 8'd200;

	// frequency word numerators: 0x19000000 times post divider 6 or 4
	localparam logic [31:0] FREQ_NUM_HIGH = 32'h9600_0000;
	localparam logic [31:0] FREQ_NUM_LOW  = 32'h6400_0000;

	// step word numerator
	localparam logic [25:0] STEP_NUM = 26'h360_0000;

	// step word saturation limit
	localparam logic [13:0] STEP_MAX = 14'h3FFF;

	// reciprocals of 25: x/25 == (x * RECIP) >> SHIFT over the ranges used
	localparam logic [17:0] RECIP25_S22 = 18'd167773;
	localparam int          SHIFT_S22   = 22;
	localparam logic [25:0] RECIP25_S30 = 26'd42949673;
	localparam int          SHIFT_S30   = 30;

endpackage
`default_nettype wire

FILE: hw/rtl/pscc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, then a
// round-half-up stage. Caller guarantees num < den << Q_W.
module pscc_div #(
	parameter int NUM_W  = 32,
	parameter int DEN_W  = 12,
	parameter int Q_W    = 26,
	parameter int SIDE_W = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	input  wire logic [SIDE_W-1:0] side,
	output logic                   out_valid,
	output logic [Q_W:0]           quo,
	output logic [SIDE_W-1:0]      out_side
);

	logic [DEN_W-1:0]  rem_s  [Q_W];
	logic [Q_W-1:0]    low_s  [Q_W];
	logic [DEN_W-1:0]  den_s  [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];
	logic [Q_W-1:0]    v_s;
	logic [DEN_W-1:0]  rem_n  [Q_W];
	logic [Q_W-1:0]    low_n  [Q_W];
	logic              rnd;
	logic [Q_W:0]      quo_s;
	logic [SIDE_W-1:0] side_rs;
	logic              v_rs;

	// one restoring step: shift in next dividend bit, subtract if it fits
	function automatic logic [DEN_W+Q_W-1:0] div_step(
		input logic [DEN_W-1:0] r,
		input logic [Q_W-1:0]   l,
		input logic [DEN_W-1:0] d
	);
		logic [DEN_W:0]   trial;
		logic             ge;
		logic [DEN_W-1:0] nr;
		trial = {r, l[Q_W-1]};
		ge    = (trial >= {1'b0, d});
		nr    = ge ? DEN_W'(trial - {1'b0, d}) : trial[DEN_W-1:0];
		return {nr, l[Q_W-2:0], ge};
	endfunction

	// step logic of every stage
	always_comb begin
		{rem_n[0], low_n[0]} = div_step(DEN_W'(num[NUM_W-1:Q_W]), num[Q_W-1:0], den);
		for (int k = 1; k < Q_W; k++) begin
			{rem_n[k], low_n[k]} = div_step(rem_s[k-1], low_s[k-1], den_s[k-1]);
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s  <= '0;
			v_rs <= 1'b0;
		end else if (en) begin
			v_s  <= {v_s[Q_W-2:0], in_valid};
			v_rs <= v_s[Q_W-1];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < Q_W; k++) begin
				rem_s[k] <= rem_n[k];
				low_s[k] <= low_n[k];
			end
			den_s[0]  <= den;
			side_s[0] <= side;
			for (int k = 1; k < Q_W; k++) begin
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// round half up: bump when twice the remainder reaches the divisor
	assign rnd = ({rem_s[Q_W-1], 1'b0} >= {1'b0, den_s[Q_W-1]});

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s   <= {1'b0, low_s[Q_W-1]} + (Q_W+1)'(rnd);
			side_rs <= side_s[Q_W-1];
		end
	end

	assign out_valid = v_rs;
	assign quo       = quo_s;
	assign out_side  = side_rs;

endmodule
`default_nettype wire

FILE: hw/rtl/pll_ssc_coefficient_calc_top.sv
// Throughput: one request per cycle; the whole pipeline holds while a
// result waits, so in_ready follows out_ready when out_valid is high.
// Depth is set by the three bit-per-stage dividers (27 + 15 + 18 stages).
// Reset (arst_n low, asynchronous) clears all stage valid bits.
`timescale 1ns / 1ps
`default_nettype none
module pll_ssc_coefficient_calc_top
	import pscc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        high_mode,
	input  wire logic [11:0] target_freq,
	input  wire logic [3:0]  feedback_divider,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [25:0]      freq_word,
	output logic [13:0]      step_word,
	output logic [16:0]      ratio_word
);

	logic        en;
	logic [11:0] freq_c;
	logic [19:0] prod_s1;
	logic        mode_s1, mode_s2;
	logic [3:0]  div_s1, div_s2;
	logic        v_s1, v_s2, v_s4, v_s5;
	logic [34:0] scl_prod;
	logic [11:0] scaled_s2;
	logic        fw_v;
	logic [26:0] fw_q;
	logic [3:0]  fw_div;
	logic [25:0] fw;
	logic [27:0] y_s4;
	logic [29:0] t_s4;
	logic [25:0] fw_s4, fw_s5;
	logic [51:0] sdiv_prod;
	logic [52:0] spr_prod;
	logic [20:0] sdiv_s5;
	logic [21:0] spread_s5;
	logic        sw_v;
	logic [14:0] sw_q;
	logic [47:0] sw_side;
	logic [13:0] sw_sat;
	logic        rw_v;
	logic [17:0] rw_q;
	logic [39:0] rw_side;

	// global advance: hold everything while a result waits
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: clamp frequency, multiply by (200 - divider)
	assign freq_c = (target_freq < FREQ_MIN) ? FREQ_MIN : target_freq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s4 <= fw_v;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 20'(SCALE_DEN - 8'(feedback_divider)) * 20'(freq_c);
			mode_s1 <= high_mode;
			div_s1  <= feedback_divider;
		end
	end

	// stage 2: divide by 200 as (p / 8) / 25 via reciprocal
	assign scl_prod = 35'(prod_s1[19:3]) * 35'(RECIP25_S22);

	always_ff @(posedge clk) begin
		if (en) begin
			scaled_s2 <= scl_prod[SHIFT_S22+11:SHIFT_S22];
			mode_s2   <= mode_s1;
			div_s2    <= div_s1;
		end
	end

	// frequency word divider
	pscc_div #(
		.NUM_W(32), .DEN_W(12), .Q_W(26), .SIDE_W(4)
	) u_div_freq (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s2),
		.num(mode_s2 ? FREQ_NUM_HIGH : FREQ_NUM_LOW),
		.den(scaled_s2),
		.side(div_s2),
		.out_valid(fw_v), .quo(fw_q), .out_side(fw_div)
	);

	assign fw = fw_q[25:0];

	// stage A: fw * 3 and divider * fw
	always_ff @(posedge clk) begin
		if (en) begin
			y_s4  <= {2'b0, fw} + {1'b0, fw, 1'b0};
			t_s4  <= 30'(fw_div) * 30'(fw);
			fw_s4 <= fw;
		end
	end

	// stage B: step divisor = y/100 (3fw/100), spread = t/200, both via reciprocal of 25
	assign sdiv_prod = 52'(y_s4[27:2]) * 52'(RECIP25_S30);
	assign spr_prod  = 53'(t_s4[29:3]) * 53'(RECIP25_S30);

	always_ff @(posedge clk) begin
		if (en) begin
			sdiv_s5   <= sdiv_prod[SHIFT_S30+20:SHIFT_S30];
			spread_s5 <= spr_prod[SHIFT_S30+21:SHIFT_S30];
			fw_s5     <= fw_s4;
		end
	end

	// step word divider
	pscc_div #(
		.NUM_W(26), .DEN_W(21), .Q_W(14), .SIDE_W(48)
	) u_div_step (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s5),
		.num(STEP_NUM),
		.den(sdiv_s5),
		.side({fw_s5, spread_s5}),
		.out_valid(sw_v), .quo(sw_q), .out_side(sw_side)
	);

	assign sw_sat = (sw_q > {1'b0, STEP_MAX}) ? STEP_MAX : sw_q[13:0];

	// ratio word divider, uses the unsaturated step quotient
	pscc_div #(
		.NUM_W(22), .DEN_W(15), .Q_W(17), .SIDE_W(40)
	) u_div_ratio (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(sw_v),
		.num(sw_side[21:0]),
		.den(sw_q),
		.side({sw_side[47:22], sw_sat}),
		.out_valid(rw_v), .quo(rw_q), .out_side(rw_side)
	);

	assign out_valid  = rw_v;
	assign freq_word  = rw_side[39:14];
	assign step_word  = rw_side[13:0];
	assign ratio_word = rw_q[16:0];

endmodule
`default_nettype wire

FILE: hw/rtl/pscc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "pll_ssc_coefficient_calc_top_assert.svh"
module pscc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        high_mode,
	input wire logic [11:0] target_freq,
	input wire logic [3:0]  feedback_divider,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [25:0] freq_word,
	input wire logic [13:0] step_word,
	input wire logic [16:0] ratio_word
);

	// a stalled result stays
	`PSCC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// a stalled result keeps its words
	`PSCC_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(freq_word) && $stable(step_word) && $stable(ratio_word))

	// a waiting request stays with its fields
	`PSCC_ASSERT_NXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(high_mode) && $stable(target_freq) && $stable(feedback_divider))

	// pipeline takes requests exactly when it can advance
	`PSCC_ASSERT_IMP(a_ready_adv, clk, arst_n, 1'b1, in_ready == (!out_valid || out_ready))

	// frequency word is never zero for a clamped frequency
	`PSCC_ASSERT_IMP(a_fw_nonzero, clk, arst_n, out_valid, freq_word != 26'd0)

endmodule

bind pll_ssc_coefficient_calc_top pscc_checker u_pscc_checker (.*);
`default_nettype wire

FILE: sim/pll_ssc_coefficient_calc_top_test.sv
`timescale 1ns / 1ps
module pll_ssc_coefficient_calc_top_test;
	import pscc_pkg::*;

	typedef struct packed {
		logic        mode;
		logic [11:0] freq;
		logic [3:0]  div;
	} ssc_req_t;

	typedef struct packed {
		logic [25:0] fw;
		logic [13:0] sw;
		logic [16:0] rw;
	} ssc_coef_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 200;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        high_mode;
	logic [11:0] target_freq;
	logic [3:0]  feedback_divider;
	logic        out_valid;
	logic        out_ready;
	logic [25:0] freq_word;
	logic [13:0] step_word;
	logic [16:0] ratio_word;

	ssc_req_t  pending_reqs[$];
	ssc_coef_t coef_expected[$];
	int        errors;
	int        accepted_reqs;
	int        checked_coefs;
	int        src_idle_pct;
	int        snk_idle_pct;
	int        hold_cycles;
	int        quiet_cycles;

	pll_ssc_coefficient_calc_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.high_mode(high_mode), .target_freq(target_freq),
		.feedback_divider(feedback_divider),
		.out_valid(out_valid), .out_ready(out_ready),
		.freq_word(freq_word), .step_word(step_word), .ratio_word(ratio_word)
	);

	// round-half-up division
	function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		if (d == 0)
			return 0;
		q = n / d;
		r = n - q * d;
		if (d - r <= r)
			q++;
		return q;
	endfunction

	// coefficient predictor
	function automatic ssc_coef_t calc_coefs(ssc_req_t rq);
		longint unsigned f;
		longint unsigned scaled;
		longint unsigned fw;
		longint unsigned sdiv;
		longint unsigned spread;
		longint unsigned sw;
		longint unsigned rw;
		ssc_coef_t c;
		f = rq.freq < 64 ? 64 : rq.freq;
		scaled = ((200 - rq.div) * f) / 200;
		fw = rdiv(64'h1900_0000 * (rq.mode ? 6 : 4), scaled);
		sdiv = (fw * 30) / 1000;
		spread = (rq.div * fw) / 200;
		sw = rdiv(64'h0360_0000, sdiv);
		rw = rdiv(spread, sw);
		c.fw = fw[25:0];
		c.sw = sw > 16383 ? 14'h3FFF : sw[13:0];
		c.rw = rw[16:0];
		return c;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			high_mode <= 1'b0;
			target_freq <= '0;
			feedback_divider <= '0;
		end else begin
			if (in_valid && in_ready) begin
				coef_expected.push_back(calc_coefs({high_mode, target_freq, feedback_divider}));
				accepted_reqs++;
			end
			if ((!in_valid || in_ready) && pending_reqs.size() > 0
					&& $urandom_range(99) >= src_idle_pct) begin
				in_valid <= 1'b1;
				{high_mode, target_freq, feedback_divider} <= pending_reqs.pop_front();
			end else if (!in_valid || in_ready) begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		ssc_coef_t exp_c;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (coef_expected.size() == 0) begin
					$display("%0t: unexpected result fw=%0d sw=%0d rw=%0d",
						$time, freq_word, step_word, ratio_word);
					errors++;
				end else begin
					exp_c = coef_expected.pop_front();
					checked_coefs++;
					if (freq_word !== exp_c.fw) begin
						$display("%0t: freq_word exp %0d got %0d", $time, exp_c.fw, freq_word);
						errors++;
					end
					if (step_word !== exp_c.sw) begin
						$display("%0t: step_word exp %0d got %0d", $time, exp_c.sw, step_word);
						errors++;
					end
					if (ratio_word !== exp_c.rw) begin
						$display("%0t: ratio_word exp %0d got %0d", $time, exp_c.rw, ratio_word);
						errors++;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// watchdog on accept activity
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: %0d requests pending, %0d results expected",
				pending_reqs.size(), coef_expected.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic add_req(logic m, logic [11:0] f, logic [3:0] d);
		ssc_req_t rq;
		rq.mode = m;
		rq.freq = f;
		rq.div = d;
		pending_reqs.push_back(rq);
	endtask

	task automatic add_random(int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: add_req(1'($urandom), 12'($urandom_range(63)), 4'($urandom));
				1: add_req(1'b0, 12'($urandom_range(4095, 3500)), 4'($urandom_range(1)));
				default: add_req(1'($urandom), 12'($urandom), 4'($urandom));
			endcase
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_valid || coef_expected.size() > 0)
			@(posedge clk);
	endtask

	// stimulus
	initial begin
		errors = 0;
		accepted_reqs = 0;
		checked_coefs = 0;
		hold_cycles = 0;
		quiet_cycles = 0;
		src_idle_pct = 16;
		snk_idle_pct = 60;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, low-range clamp
		add_req(1'b0, 12'd64, 4'd0);
		add_req(1'b1, 12'd64, 4'd15);
		add_req(1'b0, 12'd4095, 4'd0);
		add_req(1'b1, 12'd4095, 4'd0);
		add_req(1'b0, 12'd4095, 4'd15);
		add_req(1'b1, 12'd4095, 4'd15);
		add_req(1'b0, 12'd0, 4'd0);
		add_req(1'b1, 12'd63, 4'd7);
		add_req(1'b0, 12'd1, 4'd15);
		add_req(1'b0, 12'd3800, 4'd1);
		add_req(1'b1, 12'd2048, 4'd8);
		add_req(1'b0, 12'd65, 4'd1);
		add_req(1'b1, 12'd1000, 4'd3);

		// phase 1: sender idles a little, receiver a lot
		add_random(280);
		wait_drained();

		// phase 2: receiver idles a little; sender idles not at all at first, then a lot; long receiver hold-off
		src_idle_pct = 60;
		snk_idle_pct = 16;
		hold_cycles = 300;
		src_idle_pct = 0;
		add_random(280);
		repeat (100) @(posedge clk);
		src_idle_pct = 60;
		wait_drained();

		// phase 3: no idling
		src_idle_pct = 0;
		snk_idle_pct = 0;
		add_random(280);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d requests over three stall mixes and a long output hold-off",
			accepted_reqs);
		$display("checked %0d results, %0d mismatches", checked_coefs, errors);
		if (errors == 0 && coef_expected.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
